// ===== rtl/folt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// folt_pkg
// Shared constants, types and helpers of the first-order lag block.
// ----------------------------------------------------------------------------
package folt_pkg;

    // Data path and slicing limits
    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_SLICES  = 32;
    localparam int COEF_A_W    = 17;
    localparam int COEF_B_W    = 18;
    localparam int MODE_W      = 2;
    localparam int SLICE_CFG_W = 6;
    localparam int CFG_IDX_W   = 3;

    // Slice counter holds 1..MAX_SLICES; remainder of |diff|/n stays below n
    localparam int SLICE_W   = $clog2(MAX_SLICES + 1);
    localparam int REM_W     = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int DIV_CNT_W = $clog2(DATA_WIDTH);

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_K       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITER_MODE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT  = 3'd7;

    // Limiter modes (spare code behaves as non-windup)
    localparam logic [MODE_W-1:0] LIM_OFF       = 2'd0;
    localparam logic [MODE_W-1:0] LIM_WINDUP    = 2'd1;
    localparam logic [MODE_W-1:0] LIM_NONWINDUP = 2'd2;
    localparam logic [MODE_W-1:0] LIM_SPARE     = 2'd3;

    // Step modes (spare code behaves as pure gain)
    localparam logic [MODE_W-1:0] STEP_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] STEP_SLICED = 2'd1;
    localparam logic [MODE_W-1:0] STEP_GAIN   = 2'd2;
    localparam logic [MODE_W-1:0] STEP_SPARE  = 2'd3;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] gain_k;
        logic        [COEF_A_W-1:0]   coef_a;
        logic signed [COEF_B_W-1:0]   coef_b;
        logic signed [DATA_WIDTH-1:0] upper_limit;
        logic signed [DATA_WIDTH-1:0] lower_limit;
        logic        [MODE_W-1:0]     limiter_mode;
        logic        [MODE_W-1:0]     step_mode;
        logic        [SLICE_CFG_W-1:0] slice_count;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_XI,
        S_M1,
        S_KX,
        S_SUM,
        S_M2,
        S_S,
        S_M3,
        S_Z,
        S_UPD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_GAIN,
        MUL_COEF_A,
        MUL_COEF_B
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     xi_load;
        logic     xi_interp;
        logic     latch_inc;
        logic     acc_step;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     kx_load;
        logic     sum_load;
        logic     s_load;
        logic     z_load;
        logic     upd_load;
        logic     upd_gain;
        logic     out_load;
        logic     prev_load;
    } t_cmd;

    // Effective slice count: zero acts as one, clipped at MAX_SLICES
    function automatic logic [SLICE_W-1:0] eff_slices(input logic [SLICE_CFG_W-1:0] count);
        logic [SLICE_W-1:0] res;
        if (count == '0) begin
            res = SLICE_W'(1);
        end else if (int'(count) > MAX_SLICES) begin
            res = SLICE_W'(MAX_SLICES);
        end else begin
            res = SLICE_W'(count);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/folt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// folt_ctrl
// Sequencer: divider count, slice loop and result handshake.
// ----------------------------------------------------------------------------
module folt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    input  wire folt_pkg::t_cfg  i_cfg,
    output folt_pkg::t_cmd       o_cmd
);

    localparam logic [folt_pkg::DIV_CNT_W-1:0] DIV_LAST =
        folt_pkg::DIV_CNT_W'(folt_pkg::DATA_WIDTH - 1);

    folt_pkg::t_state                 r_state, n_state;
    logic [folt_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [folt_pkg::SLICE_W-1:0]     r_slice, n_slice;
    logic                             r_out_valid, n_out_valid;

    logic                             w_sliced;
    logic                             w_pure;
    logic [folt_pkg::SLICE_W-1:0]     w_nsl;

    assign w_sliced = (i_cfg.step_mode == folt_pkg::STEP_SLICED);
    assign w_pure   = i_cfg.step_mode inside {folt_pkg::STEP_GAIN, folt_pkg::STEP_SPARE};
    assign w_nsl    = folt_pkg::eff_slices(i_cfg.slice_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= folt_pkg::S_IDLE;
            r_cnt       <= '0;
            r_slice     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_slice     <= n_slice;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_slice     = r_slice;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            folt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_slice    = folt_pkg::SLICE_W'(1);
                    n_cnt      = '0;
                    if (i_cfg.gain_k == '0) begin
                        n_state = folt_pkg::S_OUT;
                    end else if (w_sliced) begin
                        n_state = folt_pkg::S_DIV;
                    end else begin
                        n_state = folt_pkg::S_XI;
                    end
                end
            end
            folt_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = folt_pkg::S_XI;
                end
            end
            folt_pkg::S_XI: begin
                o_cmd.xi_load   = 1'b1;
                o_cmd.xi_interp = w_sliced;
                o_cmd.latch_inc = w_sliced;
                n_state         = folt_pkg::S_M1;
            end
            folt_pkg::S_M1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = folt_pkg::MUL_GAIN;
                o_cmd.acc_step = w_sliced;
                n_state        = folt_pkg::S_KX;
            end
            folt_pkg::S_KX: begin
                o_cmd.kx_load = 1'b1;
                n_state       = w_pure ? folt_pkg::S_UPD : folt_pkg::S_SUM;
            end
            folt_pkg::S_SUM: begin
                o_cmd.sum_load = 1'b1;
                n_state        = folt_pkg::S_M2;
            end
            folt_pkg::S_M2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = folt_pkg::MUL_COEF_A;
                n_state       = folt_pkg::S_S;
            end
            folt_pkg::S_S: begin
                o_cmd.s_load = 1'b1;
                n_state      = folt_pkg::S_M3;
            end
            folt_pkg::S_M3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = folt_pkg::MUL_COEF_B;
                n_state       = folt_pkg::S_Z;
            end
            folt_pkg::S_Z: begin
                o_cmd.z_load    = 1'b1;
                // next slice input is formed here, overlapping the store update
                o_cmd.xi_load   = w_sliced;
                o_cmd.xi_interp = 1'b1;
                if (w_sliced && (r_slice < w_nsl)) begin
                    n_slice = r_slice + folt_pkg::SLICE_W'(1);
                    n_state = folt_pkg::S_M1;
                end else begin
                    n_state = folt_pkg::S_UPD;
                end
            end
            folt_pkg::S_UPD: begin
                o_cmd.upd_load = 1'b1;
                o_cmd.upd_gain = w_pure;
                n_state        = folt_pkg::S_OUT;
            end
            folt_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.prev_load = w_sliced;
                    n_out_valid     = 1'b1;
                    n_state         = folt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = folt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != folt_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != folt_pkg::S_IDLE))
        else $error("accepted sample did not start a run");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == folt_pkg::S_OUT))
        else $error("result raised outside the output state");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == folt_pkg::S_DIV && r_cnt == DIV_LAST) |=> (r_state == folt_pkg::S_XI))
        else $error("divider did not hand over after its last bit");

    a_out_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == folt_pkg::S_OUT && !r_out_valid)
            |=> (r_state == folt_pkg::S_IDLE && r_out_valid))
        else $error("free output slot not filled");

endmodule
`default_nettype wire

// ===== rtl/folt_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// folt_dp
// Datapath: interpolation divider, shared multiplier, round/saturate, limiter.
// ----------------------------------------------------------------------------
module folt_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire folt_pkg::t_cmd                      i_cmd,
    input  wire folt_pkg::t_cfg                      i_cfg,
    input  wire logic signed [folt_pkg::DATA_WIDTH-1:0] i_sample_in,
    output logic signed [folt_pkg::DATA_WIDTH-1:0]   o_sample_out,
    output logic                                     o_at_upper,
    output logic                                     o_at_lower
);

    localparam int DW     = folt_pkg::DATA_WIDTH;
    localparam int PROD_W = 2 * DW + 1;
    localparam int WIDE_W = PROD_W + 2;
    localparam int RW     = folt_pkg::REM_W;

    localparam logic signed [WIDE_W-1:0] Q_MAX =
        {{(WIDE_W - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] Q_MIN =
        {{(WIDE_W - DW + 1){1'b1}}, {(DW - 1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] RND_HALF = WIDE_W'(1) << (folt_pkg::FRAC_BITS - 1);
    localparam logic signed [WIDE_W-1:0] RND_TRIM = RND_HALF - WIDE_W'(1);

    function automatic logic signed [DW-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic signed [DW-1:0] res;
        if (v > Q_MAX) begin
            res = DW'(Q_MAX);
        end else if (v < Q_MIN) begin
            res = DW'(Q_MIN);
        end else begin
            res = v[DW-1:0];
        end
        return res;
    endfunction

    // round half up at bit 16, then saturate
    function automatic logic signed [DW-1:0] rnd_sat(input logic signed [PROD_W-1:0] p);
        logic signed [WIDE_W-1:0] t;
        t = WIDE_W'(p) + RND_HALF;
        return sat_q(t >>> folt_pkg::FRAC_BITS);
    endfunction

    // model state
    logic signed [DW-1:0]     r_store, r_lag, r_prev, r_held;
    // working registers
    logic signed [DW-1:0]     r_x, r_xi, r_kx;
    logic signed [DW:0]       r_sum;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_neg;
    logic [DW-1:0]            r_accq, r_qa;
    logic [RW-1:0]            r_accr, r_ra;
    logic                     r_fu, r_fl;
    logic signed [DW-1:0]     r_out_y;
    logic                     r_out_fu, r_out_fl;

    logic [folt_pkg::SLICE_W-1:0] w_nsl;
    logic [RW:0]              w_nw, w_dt, w_at;
    logic                     w_dge, w_ac;
    logic signed [DW:0]       w_d1, w_d2, w_p33, w_q33, w_xi33;
    logic signed [DW:0]       w_ma;
    logic signed [DW-1:0]     w_mb;
    logic signed [DW-1:0]     w_s0, w_s, w_z, w_y;
    logic                     w_s_fu, w_s_fl, w_u_fu, w_u_fl;
    logic signed [WIDE_W-1:0] w_zw;
    logic signed [DW:0]       w_d;
    logic                     w_d_pos, w_d_neg, w_nonwind;

    assign w_nsl     = folt_pkg::eff_slices(i_cfg.slice_count);
    assign w_nw      = (RW + 1)'(w_nsl);
    assign w_nonwind = i_cfg.limiter_mode inside {folt_pkg::LIM_NONWINDUP, folt_pkg::LIM_SPARE};

    // |x - x0| and its sign
    assign w_d1 = (DW + 1)'(i_sample_in) - (DW + 1)'(r_prev);
    assign w_d2 = (DW + 1)'(r_prev) - (DW + 1)'(i_sample_in);

    // restoring divide step, one quotient bit a cycle
    assign w_dt  = {r_accr, r_accq[DW-1]};
    assign w_dge = (w_dt >= w_nw);

    // running quotient/remainder of |diff| * i / n
    assign w_at = (RW + 1)'(r_accr) + (RW + 1)'(r_ra);
    assign w_ac = (w_at >= w_nw);

    // interpolated input x0 +/- Q
    assign w_p33  = (DW + 1)'(r_prev);
    assign w_q33  = {1'b0, r_accq};
    assign w_xi33 = r_neg ? (w_p33 - w_q33) : (w_p33 + w_q33);

    always_comb begin
        case (i_cmd.mul_sel)
            folt_pkg::MUL_GAIN: begin
                w_ma = (DW + 1)'(r_xi);
                w_mb = i_cfg.gain_k;
            end
            folt_pkg::MUL_COEF_A: begin
                w_ma = r_sum;
                w_mb = DW'(signed'({1'b0, i_cfg.coef_a}));
            end
            folt_pkg::MUL_COEF_B: begin
                w_ma = (DW + 1)'(signed'(i_cfg.coef_b));
                w_mb = r_lag;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // integrate: state from product, clamped only in non-windup mode
    always_comb begin
        w_s0   = rnd_sat(r_prod);
        w_s    = w_s0;
        w_s_fu = 1'b0;
        w_s_fl = 1'b0;
        if (w_nonwind) begin
            if (w_s0 > i_cfg.upper_limit) begin
                w_s    = i_cfg.upper_limit;
                w_s_fu = 1'b1;
            end else if (w_s0 < i_cfg.lower_limit) begin
                w_s    = i_cfg.lower_limit;
                w_s_fl = 1'b1;
            end
        end
    end

    // kx - rnd(p) folded into one add: floor((kx<<16) - p + 2^15 - 1) >> 16
    assign w_zw = (WIDE_W'(r_kx) <<< folt_pkg::FRAC_BITS) - WIDE_W'(r_prod) + RND_TRIM;
    assign w_z  = sat_q(w_zw >>> folt_pkg::FRAC_BITS);

    // update: output from state; derivative sign is kx - s
    assign w_d     = (DW + 1)'(r_kx) - (DW + 1)'(r_lag);
    assign w_d_neg = w_d[DW];
    assign w_d_pos = !w_d[DW] && (w_d != '0);

    always_comb begin
        w_y    = r_lag;
        w_u_fu = 1'b0;
        w_u_fl = 1'b0;
        if (i_cmd.upd_gain) begin
            w_y = r_kx;
        end else begin
            case (i_cfg.limiter_mode)
                folt_pkg::LIM_WINDUP: begin
                    if (r_lag > i_cfg.upper_limit) begin
                        w_y    = i_cfg.upper_limit;
                        w_u_fu = 1'b1;
                    end else if (r_lag < i_cfg.lower_limit) begin
                        w_y    = i_cfg.lower_limit;
                        w_u_fl = 1'b1;
                    end
                end
                folt_pkg::LIM_NONWINDUP, folt_pkg::LIM_SPARE: begin
                    if ((r_lag >= i_cfg.upper_limit) && w_d_pos) begin
                        w_y    = i_cfg.upper_limit;
                        w_u_fu = 1'b1;
                    end else if ((r_lag <= i_cfg.lower_limit) && w_d_neg) begin
                        w_y    = i_cfg.lower_limit;
                        w_u_fl = 1'b1;
                    end
                end
                default: begin
                    w_y = r_lag;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_lag   <= '0;
            r_prev  <= '0;
            r_held  <= '0;
        end else begin
            if (i_cmd.s_load) begin
                r_lag <= w_s;
            end
            if (i_cmd.z_load) begin
                r_store <= w_z;
            end
            if (i_cmd.upd_load) begin
                r_held <= w_y;
            end
            if (i_cmd.prev_load) begin
                r_prev <= r_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_sample_in;
            r_neg  <= w_d1[DW];
            r_accq <= w_d1[DW] ? w_d2[DW-1:0] : w_d1[DW-1:0];
            r_accr <= '0;
            r_fu   <= 1'b0;
            r_fl   <= 1'b0;
        end else begin
            r_fu <= r_fu | (i_cmd.s_load & w_s_fu) | (i_cmd.upd_load & w_u_fu);
            r_fl <= r_fl | (i_cmd.s_load & w_s_fl) | (i_cmd.upd_load & w_u_fl);
        end
        if (i_cmd.div_step) begin
            r_accq <= {r_accq[DW-2:0], w_dge};
            r_accr <= w_dge ? RW'(w_dt - w_nw) : RW'(w_dt);
        end
        if (i_cmd.latch_inc) begin
            r_qa <= r_accq;
            r_ra <= r_accr;
        end
        if (i_cmd.acc_step) begin
            r_accq <= r_accq + r_qa + DW'(w_ac);
            r_accr <= w_ac ? RW'(w_at - w_nw) : RW'(w_at);
        end
        if (i_cmd.xi_load) begin
            r_xi <= i_cmd.xi_interp ? w_xi33[DW-1:0] : r_x;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_ma * w_mb;
        end
        if (i_cmd.kx_load) begin
            r_kx <= rnd_sat(r_prod);
        end
        if (i_cmd.sum_load) begin
            r_sum <= (DW + 1)'(r_store) + (DW + 1)'(r_kx);
        end
        if (i_cmd.out_load) begin
            r_out_y  <= r_held;
            r_out_fu <= r_fu;
            r_out_fl <= r_fl;
        end
    end

    assign o_sample_out = r_out_y;
    assign o_at_upper   = r_out_fu;
    assign o_at_lower   = r_out_fl;

endmodule
`default_nettype wire

// ===== rtl/first_order_lag_trapezoid_limiter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_order_lag_trapezoid_limiter
// Run length is set by the bit-serial divider and the shared multiplier
// (three uses per slice). One sample in flight; the next is accepted once
// the result is staged in the output register.
// Sync active-low reset: gain 1.0, limits full scale, filter state zero.
// ----------------------------------------------------------------------------
module first_order_lag_trapezoid_limiter (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // sample channel
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic signed [folt_pkg::DATA_WIDTH-1:0] i_sample_in,
    // result channel
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic signed [folt_pkg::DATA_WIDTH-1:0]      o_sample_out,
    output logic                                        o_at_upper,
    output logic                                        o_at_lower,
    // configuration write channel
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [folt_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [folt_pkg::DATA_WIDTH-1:0]        i_cfg_data
);

    // Register file. Software must write only while the block is idle, so the
    // sequencer and datapath see stable values for a whole sample (not enforced).
    folt_pkg::t_cfg r_cfg;
    folt_pkg::t_cmd w_cmd;

    // Writes are always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_k       <= folt_pkg::DATA_WIDTH'(65536);   // 1.0 in Q16.16
            r_cfg.coef_a       <= '0;
            r_cfg.coef_b       <= '0;
            r_cfg.upper_limit  <= {1'b0, {(folt_pkg::DATA_WIDTH - 1){1'b1}}};
            r_cfg.lower_limit  <= {1'b1, {(folt_pkg::DATA_WIDTH - 1){1'b0}}};
            r_cfg.limiter_mode <= folt_pkg::LIM_OFF;
            r_cfg.step_mode    <= folt_pkg::STEP_NORMAL;
            r_cfg.slice_count  <= folt_pkg::SLICE_CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            // narrow fields keep the low bits of the transfer
            case (i_cfg_index)
                folt_pkg::CFG_GAIN_K: begin
                    r_cfg.gain_k <= i_cfg_data;
                end
                folt_pkg::CFG_COEF_A: begin
                    r_cfg.coef_a <= i_cfg_data[folt_pkg::COEF_A_W-1:0];
                end
                folt_pkg::CFG_COEF_B: begin
                    r_cfg.coef_b <= i_cfg_data[folt_pkg::COEF_B_W-1:0];
                end
                folt_pkg::CFG_UPPER_LIMIT: begin
                    r_cfg.upper_limit <= i_cfg_data;
                end
                folt_pkg::CFG_LOWER_LIMIT: begin
                    r_cfg.lower_limit <= i_cfg_data;
                end
                folt_pkg::CFG_LIMITER_MODE: begin
                    r_cfg.limiter_mode <= i_cfg_data[folt_pkg::MODE_W-1:0];
                end
                folt_pkg::CFG_STEP_MODE: begin
                    r_cfg.step_mode <= i_cfg_data[folt_pkg::MODE_W-1:0];
                end
                folt_pkg::CFG_SLICE_COUNT: begin
                    r_cfg.slice_count <= i_cfg_data[folt_pkg::SLICE_CFG_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Sequencer. Per sample:
    //  - zero gain: straight to output with the held value, flags clear
    //  - pure gain: one multiply, kx becomes the held output
    //  - normal: one trapezoid slice on the sample itself
    //  - sub-sliced: |x - x0| / n by the bit-serial divider, then n slices on
    //    inputs stepped by quotient/remainder accumulation, no further divides
    // The output register parts the two sides: a result waiting on a stalled
    // sink does not stop the next sample being accepted and worked on.
    folt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg       (r_cfg),
        .o_cmd       (w_cmd)
    );

    // Datapath. Each slice: gain*x -> kx, z + kx, coef_a*(z + kx) -> s,
    // coef_b*s -> z, one shared 33x32 multiplier registered between uses.
    // Limiter flags collect over every slice and the final update.
    folt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg        (r_cfg),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out),
        .o_at_upper   (o_at_upper),
        .o_at_lower   (o_at_lower)
    );

endmodule
`default_nettype wire

// ===== test/first_order_lag_trapezoid_limiter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_order_lag_trapezoid_limiter_tb
// Self-checking bench for the trapezoidal first-order lag with limiter.
// A clocked driver transfers samples from a pending queue. At each accepted
// transfer a local fixed-point predictor works out the expected output and
// its clamp flags. A clocked monitor compares every accepted result with the
// oldest prediction. Register values change only while the block is idle,
// first in a short directed pass over the corner cases, then in random phases.
// ----------------------------------------------------------------------------
module first_order_lag_trapezoid_limiter_tb;

    typedef struct {
        logic signed [folt_pkg::DATA_WIDTH-1:0] sample_out;
        logic                                   at_upper;
        logic                                   at_lower;
    } t_lag_result;

    // Stimulus sides start from known values; reset is held low from time 0
    logic                                   i_clk       = 1'b0;
    logic                                   i_rst_n     = 1'b0;
    logic                                   i_in_valid  = 1'b0;
    logic signed [folt_pkg::DATA_WIDTH-1:0] i_sample_in = '0;
    logic                                   i_out_stall = 1'b0;
    logic                                   i_cfg_valid = 1'b0;
    logic [folt_pkg::CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [folt_pkg::DATA_WIDTH-1:0]        i_cfg_data  = '0;

    logic                                   o_in_stall;
    logic                                   o_out_valid;
    logic signed [folt_pkg::DATA_WIDTH-1:0] o_sample_out;
    logic                                   o_at_upper;
    logic                                   o_at_lower;
    logic                                   o_cfg_ready;

    first_order_lag_trapezoid_limiter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_at_upper   (o_at_upper),
        .o_at_lower   (o_at_lower),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    logic signed [folt_pkg::DATA_WIDTH-1:0] pending_samples[$];   // waiting for transfer
    t_lag_result                            predicted_outputs[$]; // oldest first

    int samples_queued   = 0;
    int results_checked  = 0;
    int fail_count       = 0;

    // Register values as the block holds them, updated at each register transfer
    folt_pkg::t_cfg cfg_copy;

    // Filter state as the block holds it
    logic signed [folt_pkg::DATA_WIDTH-1:0] lag_store;
    logic signed [folt_pkg::DATA_WIDTH-1:0] lag_integ;
    logic signed [folt_pkg::DATA_WIDTH-1:0] lag_prev_in;
    logic signed [folt_pkg::DATA_WIDTH-1:0] lag_held;

    // Clamp flags gathered over one sample
    logic clamp_up;
    logic clamp_lo;

    // ------------------------------------------------------------------------
    // Fixed-point helpers
    // ------------------------------------------------------------------------
    function automatic longint sat_data(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Round a Q32.32 product back to Q16.16: add half an LSB, floor
    function automatic longint round_q16(input longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic bit nonwindup_on();
        return cfg_copy.limiter_mode == folt_pkg::LIM_NONWINDUP ||
               cfg_copy.limiter_mode == folt_pkg::LIM_SPARE;
    endfunction

    // Integrate phase: s = a*(z + kx); state clamp only in non-windup mode
    function automatic longint integrate_phase(input longint z, input longint kx);
        longint s;
        longint up;
        longint lo;
        up = longint'($signed(cfg_copy.upper_limit));
        lo = longint'($signed(cfg_copy.lower_limit));
        s  = sat_data(round_q16(longint'(cfg_copy.coef_a) * (z + kx)));
        if (nonwindup_on()) begin
            if (s > up) begin
                s = up;
                clamp_up = 1'b1;
            end else if (s < lo) begin
                s = lo;
                clamp_lo = 1'b1;
            end
        end
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: one sample in, one expected result queued
    // ------------------------------------------------------------------------
    task automatic compute_lag_step(input logic signed [folt_pkg::DATA_WIDTH-1:0] x_in);
        longint x;
        longint gain;
        longint cb;
        longint up;
        longint lo;
        longint kx;
        longint kxi;
        longint xi;
        longint diff;
        longint z;
        longint s;
        longint y;
        longint d;
        longint n;
        t_lag_result res;
        clamp_up = 1'b0;
        clamp_lo = 1'b0;
        x    = longint'(x_in);
        gain = longint'($signed(cfg_copy.gain_k));
        cb   = longint'($signed(cfg_copy.coef_b));
        up   = longint'($signed(cfg_copy.upper_limit));
        lo   = longint'($signed(cfg_copy.lower_limit));

        // Zero gain freezes the filter state and repeats the held output
        if (gain != 0) begin
            kx = sat_data(round_q16(gain * x));
            if (cfg_copy.step_mode == folt_pkg::STEP_NORMAL ||
                cfg_copy.step_mode == folt_pkg::STEP_SLICED) begin
                if (cfg_copy.step_mode == folt_pkg::STEP_NORMAL) begin
                    lag_integ = integrate_phase(longint'(lag_store), kx);
                end else begin
                    // Zero slices act as one; counts over the maximum clip
                    n = longint'(cfg_copy.slice_count);
                    if (n < 1) begin
                        n = 1;
                    end
                    if (n > folt_pkg::MAX_SLICES) begin
                        n = folt_pkg::MAX_SLICES;
                    end
                    diff = x - longint'(lag_prev_in);
                    z    = longint'(lag_store);
                    s    = longint'(lag_integ);
                    for (longint i = 1; i <= n; i++) begin
                        // Truncating divide: last slice lands on x exactly
                        xi  = longint'(lag_prev_in) + (diff * i) / n;
                        kxi = sat_data(round_q16(gain * xi));
                        s   = integrate_phase(z, kxi);
                        z   = sat_data(kxi - round_q16(cb * s));
                    end
                    lag_integ = s;
                end

                // Update phase: output clamp, then next stored value
                s = longint'(lag_integ);
                y = s;
                d = kx - s;
                if (cfg_copy.limiter_mode == folt_pkg::LIM_WINDUP) begin
                    if (y > up) begin
                        y = up;
                        clamp_up = 1'b1;
                    end else if (y < lo) begin
                        y = lo;
                        clamp_lo = 1'b1;
                    end
                end else if (nonwindup_on()) begin
                    // Upper side wins when the limits are crossed
                    if (s >= up && d > 0) begin
                        y = up;
                        clamp_up = 1'b1;
                    end else if (s <= lo && d < 0) begin
                        y = lo;
                        clamp_lo = 1'b1;
                    end
                end
                lag_store = sat_data(kx - round_q16(cb * s));
                lag_held  = y;
            end else begin
                // Pure gain (spare code too): no limiter, no flags
                lag_held = kx;
            end
        end
        if (cfg_copy.step_mode == folt_pkg::STEP_SLICED) begin
            lag_prev_in = x_in;
        end

        res.sample_out = lag_held;
        res.at_upper   = clamp_up;
        res.at_lower   = clamp_lo;
        predicted_outputs.push_back(res);
    endtask

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(1, 3);
        end else if (r < 92) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    // ------------------------------------------------------------------------
    // Sample driver
    // ------------------------------------------------------------------------
    int in_gap  = 0;
    int in_calm = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
            in_calm    <= 0;
        end else begin
            // Transfer at this edge: predict from the register values now in force
            if (i_in_valid && !o_in_stall) begin
                compute_lag_step(i_sample_in);
            end
            // Calm stretches: back-to-back offers
            if (in_calm > 0) begin
                in_calm <= in_calm - 1;
            end else if ($urandom_range(0, 199) == 0) begin
                in_calm <= $urandom_range(50, 200);
            end
            // Payload only moves when nothing is held against a stall
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    i_in_valid <= 1'b0;
                    in_gap     <= in_gap - 1;
                end else if (pending_samples.size() > 0) begin
                    i_in_valid  <= 1'b1;
                    i_sample_in <= pending_samples.pop_front();
                    in_gap      <= (in_calm > 0 || $urandom_range(0, 1) == 0) ?
                                   0 : idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result stall generator, with one long hold-off while samples are still
    // being offered so that the block fills and pushes back on its input
    // ------------------------------------------------------------------------
    int  stall_left = 0;
    int  out_calm   = 0;
    bit  hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
            out_calm    <= 0;
            hold_done   <= 1'b0;
        end else if (!hold_done && results_checked >= 150 &&
                     pending_samples.size() > 0) begin
            hold_done   <= 1'b1;
            stall_left  <= 400;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (out_calm > 0) begin
                out_calm <= out_calm - 1;
            end else if ($urandom_range(0, 199) == 0) begin
                out_calm <= $urandom_range(50, 200);
            end else if ($urandom_range(0, 99) < 25) begin
                stall_left <= idle_len();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_lag_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_outputs.size() == 0) begin
                $error("unexpected result transfer: sample_out %0d", o_sample_out);
                fail_count++;
            end else begin
                want = predicted_outputs.pop_front();
                if (o_sample_out !== want.sample_out) begin
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           want.sample_out, o_sample_out);
                    fail_count++;
                end
                if (o_at_upper !== want.at_upper) begin
                    $error("at_upper mismatch: expected %0b, actual %0b",
                           want.at_upper, o_at_upper);
                    fail_count++;
                end
                if (o_at_lower !== want.at_lower) begin
                    $error("at_lower mismatch: expected %0b, actual %0b",
                           want.at_lower, o_at_lower);
                    fail_count++;
                end
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [folt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [folt_pkg::DATA_WIDTH-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            folt_pkg::CFG_GAIN_K:
                cfg_copy.gain_k       = data;
            folt_pkg::CFG_COEF_A:
                cfg_copy.coef_a       = data[folt_pkg::COEF_A_W-1:0];
            folt_pkg::CFG_COEF_B:
                cfg_copy.coef_b       = data[folt_pkg::COEF_B_W-1:0];
            folt_pkg::CFG_UPPER_LIMIT:
                cfg_copy.upper_limit  = data;
            folt_pkg::CFG_LOWER_LIMIT:
                cfg_copy.lower_limit  = data;
            folt_pkg::CFG_LIMITER_MODE:
                cfg_copy.limiter_mode = data[folt_pkg::MODE_W-1:0];
            folt_pkg::CFG_STEP_MODE:
                cfg_copy.step_mode    = data[folt_pkg::MODE_W-1:0];
            folt_pkg::CFG_SLICE_COUNT:
                cfg_copy.slice_count  = data[folt_pkg::SLICE_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send(input logic [folt_pkg::DATA_WIDTH-1:0] x);
        pending_samples.push_back(x);
        samples_queued++;
    endtask

    // Every sample yields one result, so idle means all results are back
    task automatic wait_drain();
        do @(posedge i_clk); while (results_checked < samples_queued);
        repeat (8) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int r;
        int g;
        int up;
        int lo;
        int n_eff;
        int phase_len;
        int random_items;
        logic signed [folt_pkg::DATA_WIDTH-1:0] x;

        // Reset values of the register file and state
        cfg_copy.gain_k       = 32'sd65536;
        cfg_copy.coef_a       = '0;
        cfg_copy.coef_b       = '0;
        cfg_copy.upper_limit  = 32'h7FFF_FFFF;
        cfg_copy.lower_limit  = 32'h8000_0000;
        cfg_copy.limiter_mode = folt_pkg::LIM_OFF;
        cfg_copy.step_mode    = folt_pkg::STEP_NORMAL;
        cfg_copy.slice_count  = 6'd1;
        lag_store   = '0;
        lag_integ   = '0;
        lag_prev_in = '0;
        lag_held    = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // --- directed pass ---
        // Reset values, zero coefficients: full-scale inputs
        send(32'h0000_0000);
        send(32'h7FFF_FFFF);
        send(32'h8000_0000);
        wait_drain();

        // Windup clamp, both coefficients at 1.0
        write_reg(folt_pkg::CFG_GAIN_K, 32'h0002_0000);
        write_reg(folt_pkg::CFG_COEF_A, 32'd65536);
        write_reg(folt_pkg::CFG_COEF_B, 32'd65536);
        write_reg(folt_pkg::CFG_UPPER_LIMIT, 32'h0010_0000);
        write_reg(folt_pkg::CFG_LOWER_LIMIT, 32'hFFF0_0000);
        write_reg(folt_pkg::CFG_LIMITER_MODE, folt_pkg::LIM_WINDUP);
        send(32'h7FFF_FFFF);
        send(32'h8000_0000);
        send(32'h0000_8000);
        send(32'hFFFF_8000);
        wait_drain();

        // Non-windup, coef_b at -1.0
        write_reg(folt_pkg::CFG_LIMITER_MODE, folt_pkg::LIM_NONWINDUP);
        write_reg(folt_pkg::CFG_COEF_A, 32'd20000);
        write_reg(folt_pkg::CFG_COEF_B, 32'hFFFF_0000);
        send(32'h7FFF_FFFF);
        send(32'h7FFF_FFFF);
        send(32'h8000_0000);
        send(32'h8000_0000);
        wait_drain();

        // Spare limiter code with crossed limits
        write_reg(folt_pkg::CFG_LIMITER_MODE, folt_pkg::LIM_SPARE);
        write_reg(folt_pkg::CFG_UPPER_LIMIT, 32'hFFFF_0000);
        write_reg(folt_pkg::CFG_LOWER_LIMIT, 32'h0001_0000);
        send(32'h0005_0000);
        send(32'hFFFB_0000);
        wait_drain();

        // Zero gain holds; in sliced mode the previous input still moves
        write_reg(folt_pkg::CFG_GAIN_K, 32'h0000_0000);
        send(32'h1234_5678);
        wait_drain();
        write_reg(folt_pkg::CFG_STEP_MODE, folt_pkg::STEP_SLICED);
        send(32'h0003_0000);
        wait_drain();

        // Pure gain at both gain extremes, spare step code included
        write_reg(folt_pkg::CFG_LIMITER_MODE, folt_pkg::LIM_OFF);
        write_reg(folt_pkg::CFG_GAIN_K, 32'h8000_0000);
        write_reg(folt_pkg::CFG_STEP_MODE, folt_pkg::STEP_SPARE);
        send(32'h7FFF_FFFF);
        send(32'h8000_0000);
        wait_drain();
        write_reg(folt_pkg::CFG_GAIN_K, 32'h7FFF_FFFF);
        write_reg(folt_pkg::CFG_STEP_MODE, folt_pkg::STEP_GAIN);
        send(32'h8000_0000);
        send(32'h0000_0001);
        wait_drain();

        // Sliced mode: zero count, count above the maximum, then a normal one
        write_reg(folt_pkg::CFG_GAIN_K, 32'h0001_0000);
        write_reg(folt_pkg::CFG_UPPER_LIMIT, 32'h7FFF_FFFF);
        write_reg(folt_pkg::CFG_LOWER_LIMIT, 32'h8000_0000);
        write_reg(folt_pkg::CFG_LIMITER_MODE, folt_pkg::LIM_WINDUP);
        write_reg(folt_pkg::CFG_STEP_MODE, folt_pkg::STEP_SLICED);
        write_reg(folt_pkg::CFG_SLICE_COUNT, 32'd0);
        send(32'h0004_0000);
        wait_drain();
        write_reg(folt_pkg::CFG_SLICE_COUNT, 32'd63);
        send(32'hFFFC_0000);
        wait_drain();
        write_reg(folt_pkg::CFG_SLICE_COUNT, 32'd5);
        send(32'h7FFF_FFFF);
        send(32'h8000_0000);
        wait_drain();

        // --- random phases: fresh register values each time, state carried over ---
        random_items = 0;
        while (random_items < 430) begin
            // Gain: mostly moderate, sometimes zero or full scale
            r = $urandom_range(0, 99);
            if (r < 8) begin
                g = 0;
            end else if (r < 15) begin
                g = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end else begin
                g = $signed($urandom()) >>> $urandom_range(12, 16);
            end
            write_reg(folt_pkg::CFG_GAIN_K, g);

            r = $urandom_range(0, 99);
            write_reg(folt_pkg::CFG_COEF_A, (r < 10) ? 0 : (r < 20) ? 65536 :
                                            int'($urandom_range(0, 65536)));
            r = $urandom_range(0, 99);
            write_reg(folt_pkg::CFG_COEF_B, (r < 10) ? -65536 : (r < 20) ? 65536 :
                                            int'($urandom_range(0, 131072)) - 65536);

            // Limits: full scale, crossed, or a window around zero
            r = $urandom_range(0, 99);
            if (r < 15) begin
                up = 32'h7FFF_FFFF;
                lo = 32'h8000_0000;
            end else if (r < 25) begin
                up = -int'($urandom_range(0, 32'h00FF_FFFF));
                lo = int'($urandom_range(1, 32'h00FF_FFFF));
            end else begin
                up = int'($urandom_range(1, 32'h0FFF_FFFF));
                lo = -int'($urandom_range(1, 32'h0FFF_FFFF));
            end
            write_reg(folt_pkg::CFG_UPPER_LIMIT, up);
            write_reg(folt_pkg::CFG_LOWER_LIMIT, lo);
            write_reg(folt_pkg::CFG_LIMITER_MODE, $urandom_range(0, 3));

            r = $urandom_range(0, 99);
            write_reg(folt_pkg::CFG_STEP_MODE,
                      (r < 40) ? folt_pkg::STEP_NORMAL :
                      (r < 75) ? folt_pkg::STEP_SLICED :
                      (r < 90) ? folt_pkg::STEP_GAIN : folt_pkg::STEP_SPARE);

            // Slice count: mostly small so that sliced phases stay short
            r = $urandom_range(0, 99);
            if (r < 60) begin
                n_eff = $urandom_range(1, 6);
            end else if (r < 75) begin
                n_eff = 0;
            end else if (r < 85) begin
                n_eff = folt_pkg::MAX_SLICES;
            end else if (r < 95) begin
                n_eff = $urandom_range(folt_pkg::MAX_SLICES + 1, 63);
            end else begin
                n_eff = $urandom_range(7, folt_pkg::MAX_SLICES - 1);
            end
            write_reg(folt_pkg::CFG_SLICE_COUNT, n_eff);

            phase_len = (cfg_copy.step_mode == folt_pkg::STEP_SLICED && n_eff > 8) ?
                        12 : 36;
            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    // Spread from about +-2.0 up to +-2048.0
                    x = $signed($urandom()) >>> $urandom_range(4, 14);
                end else if (r < 85) begin
                    x = $urandom();
                end else begin
                    case ($urandom_range(0, 6))
                        0:       x = 32'h7FFF_FFFF;
                        1:       x = 32'h8000_0000;
                        2:       x = 32'h0000_0000;
                        3:       x = 32'h0000_0001;
                        4:       x = 32'hFFFF_FFFF;
                        5:       x = 32'h0001_0000;
                        default: x = 32'hFFFF_0000;
                    endcase
                end
                send(x);
            end
            random_items += phase_len;
            wait_drain();
        end

        // Tail: let any stray result show up before the verdict
        repeat (50) @(posedge i_clk);
        if (predicted_outputs.size() != 0) begin
            $error("%0d predicted results never arrived", predicted_outputs.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
